// ===== hdl/pfba_pkg.sv =====
// shared types and constants of the page frame bitmap allocator
package pfba_pkg;

	localparam int FRAMES      = 4096;
	localparam int NUM_REGIONS = 3;
	localparam int MAP_WORDS   = FRAMES / 32;
	localparam int IDX_W       = $clog2(FRAMES);
	localparam int WORD_W      = $clog2(MAP_WORDS);
	localparam int SPAN_W      = 18;
	localparam int CNT_W       = 13;
	localparam int FRAME_W     = 20;
	localparam int ADDR_W      = 32;
	localparam int PAGE_SHIFT  = 12;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		K_ALLOC,
		K_ALLOC_ZERO,
		K_FREE,
		K_FREE_ZERO
	} kind_t;

	localparam logic [2:0] REG_BASE0 = 3'd0;
	localparam logic [2:0] REG_LEN0  = 3'd1;
	localparam logic [2:0] REG_BASE1 = 3'd2;
	localparam logic [2:0] REG_LEN1  = 3'd3;
	localparam logic [2:0] REG_BASE2 = 3'd4;
	localparam logic [2:0] REG_LEN2  = 3'd5;

	typedef struct packed {
		logic [2:0][FRAME_W-1:0] base;
		logic [2:0][CNT_W-1:0]   frames;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [CNT_W-1:0]   count;
		logic [FRAME_W-1:0] frame;
	} cmd_t;

endpackage

// ===== hdl/pfba_front.sv =====
// request intake: classifies beats and queues them for the execution unit
module pfba_front import pfba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [CNT_W-1:0]   count,
	input  logic [ADDR_W-1:0]  phys_address,
	output cmd_t               cmd,
	output logic               cmd_valid,
	input  logic               cmd_pop
);

	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] n_q;
	cmd_t       new_c;
	logic       push;

	always_comb begin
		new_c.count = count;
		new_c.frame = phys_address[ADDR_W-1:PAGE_SHIFT];
		if (opcode == OP_FREE) begin
			new_c.kind = (count == '0) ? K_FREE_ZERO : K_FREE;
		end else begin
			new_c.kind = (count == '0) ? K_ALLOC_ZERO : K_ALLOC;
		end
	end

	assign in_stall  = (n_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd       = q_q[rp_q];
	assign cmd_valid = (n_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= new_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, cmd_pop})
				2'b10:   n_q <= n_q + 2'd1;
				2'b01:   n_q <= n_q - 2'd1;
				default: n_q <= n_q;
			endcase
		end
	end

endmodule

// ===== hdl/pfba_back.sv =====
// execution unit: free map memory, first fit scan and run marking
module pfba_back import pfba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [ADDR_W-1:0]  alloc_address,
	output logic [1:0]         status
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MRD, S_MWR, S_RES} state_t;

	state_t              state_q;
	logic [1:0]          r_q, r_s1;
	logic [CNT_W-1:0]    off_q, off_s1, run_q, cnt_q;
	logic                v_s1;
	logic [SPAN_W-1:0]   idx_s1, midx_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                free_q;
	logic [ADDR_W-1:0]   addr_q, res_addr_q;
	status_t             stat_q, res_stat_q;
	logic                res_valid_q;

	logic [31:0]         mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic [31:0]         rdata_s1;
	logic                rvld_s1;

	logic [SPAN_W-1:0]   start_a [4];
	logic [CNT_W-1:0]    len_a [4];
	logic [FRAME_W-1:0]  d_a [3];
	logic                hit;
	logic [SPAN_W-1:0]   fidx, tgt_idx, scan_idx;
	logic                tgt_ok, issue_ok, bit_free, hit_s1;
	logic [CNT_W-1:0]    run_base, run_new, s_off;
	logic [FRAME_W-1:0]  a_frame;
	logic [WORD_W-1:0]   rd_addr, wr_addr;
	logic                we;
	logic [31:0]         wd;

	// usable span of each region after the cut at the end of the map
	always_comb begin
		start_a[0] = '0;
		start_a[1] = SPAN_W'(cfg.frames[0]);
		start_a[2] = SPAN_W'(cfg.frames[0]) + SPAN_W'(cfg.frames[1]);
		start_a[3] = '0;
		len_a[3]   = '0;
		for (int r = 0; r < 3; r++) begin
			if (r >= NUM_REGIONS || start_a[r] >= SPAN_W'(FRAMES)) begin
				len_a[r] = '0;
			end else if (SPAN_W'(cfg.frames[r]) > SPAN_W'(FRAMES) - start_a[r]) begin
				len_a[r] = CNT_W'(SPAN_W'(FRAMES) - start_a[r]);
			end else begin
				len_a[r] = cfg.frames[r];
			end
		end
	end

	// region lookup of one frame on free, lowest region wins
	always_comb begin
		hit  = 1'b0;
		fidx = '0;
		for (int r = 0; r < 3; r++) begin
			d_a[r] = frame_q - cfg.base[r];
		end
		for (int r = 2; r >= 0; r--) begin
			if (frame_q >= cfg.base[r] && d_a[r] < FRAME_W'(len_a[r])) begin
				hit  = 1'b1;
				fidx = start_a[r] + SPAN_W'(d_a[r]);
			end
		end
	end

	always_comb begin
		tgt_ok   = free_q ? hit : 1'b1;
		tgt_idx  = free_q ? fidx : midx_q;
		issue_ok = (off_q < len_a[r_q]);
		scan_idx = start_a[r_q] + SPAN_W'(off_q);
		bit_free = rvld_s1 ? rdata_s1[~idx_s1[4:0]] : 1'b1;
		run_base = (off_s1 == '0) ? '0 : run_q;
		run_new  = bit_free ? run_base + CNT_W'(1) : '0;
		hit_s1   = v_s1 && (run_new == cnt_q);
		s_off    = off_s1 + CNT_W'(1) - cnt_q;
		a_frame  = cfg.base[r_s1] + FRAME_W'(s_off);
		rd_addr  = (state_q == S_MRD) ? tgt_idx[IDX_W-1:5] : scan_idx[IDX_W-1:5];
		wr_addr  = idx_s1[IDX_W-1:5];
		we       = (state_q == S_MWR);
		wd       = rvld_s1 ? rdata_s1 : '1;
		wd[~idx_s1[4:0]] = free_q;
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wd;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// words never written read as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_s1 <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			off_q       <= '0;
			r_s1        <= '0;
			off_s1      <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			midx_q      <= '0;
			frame_q     <= '0;
			free_q      <= 1'b0;
			addr_q      <= '0;
			stat_q      <= ST_OK;
			res_valid_q <= 1'b0;
			res_addr_q  <= '0;
			res_stat_q  <= ST_OK;
		end else begin
			if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						addr_q  <= '0;
						cnt_q   <= cmd.count;
						frame_q <= cmd.frame;
						r_q     <= '0;
						off_q   <= '0;
						v_s1    <= 1'b0;
						case (cmd.kind)
							K_ALLOC: begin
								free_q  <= 1'b0;
								stat_q  <= ST_NOFIT;
								state_q <= S_SCAN;
							end
							K_ALLOC_ZERO: begin
								stat_q  <= ST_NOFIT;
								state_q <= S_RES;
							end
							K_FREE: begin
								free_q  <= 1'b1;
								stat_q  <= ST_OK;
								state_q <= S_MRD;
							end
							default: begin
								stat_q  <= ST_OK;
								state_q <= S_RES;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						run_q <= run_new;
					end
					if (hit_s1) begin
						v_s1    <= 1'b0;
						midx_q  <= start_a[r_s1] + SPAN_W'(s_off);
						addr_q  <= {a_frame, {PAGE_SHIFT{1'b0}}};
						stat_q  <= ST_OK;
						state_q <= S_MRD;
					end else begin
						v_s1   <= issue_ok;
						r_s1   <= r_q;
						off_s1 <= off_q;
						idx_s1 <= scan_idx;
						if (issue_ok) begin
							off_q <= off_q + CNT_W'(1);
						end else if (r_q != 2'd3) begin
							r_q   <= r_q + 2'd1;
							off_q <= '0;
						end else if (!v_s1) begin
							state_q <= S_RES;
						end
					end
				end
				S_MRD: begin
					idx_s1 <= tgt_idx;
					if (tgt_ok) begin
						state_q <= S_MWR;
					end else begin
						stat_q  <= ST_RANGE;
						cnt_q   <= cnt_q - CNT_W'(1);
						frame_q <= frame_q + FRAME_W'(1);
						midx_q  <= midx_q + SPAN_W'(1);
						state_q <= (cnt_q == CNT_W'(1)) ? S_RES : S_MRD;
					end
				end
				S_MWR: begin
					cnt_q   <= cnt_q - CNT_W'(1);
					frame_q <= frame_q + FRAME_W'(1);
					midx_q  <= midx_q + SPAN_W'(1);
					state_q <= (cnt_q == CNT_W'(1)) ? S_RES : S_MRD;
				end
				S_RES: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						res_addr_q  <= addr_q;
						res_stat_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = res_valid_q;
	assign alloc_address = res_addr_q;
	assign status        = res_stat_q;

endmodule

// ===== hdl/page_frame_bitmap_allocator_core.sv =====
// top level of the page frame bitmap allocator
// First fit allocator over a free map of FRAMES 4 KB frames held in a 32 bit wide
// memory, one bit per frame, 1 meaning free; words never written read as free, so
// no clearing pass follows reset. Requests queue two deep ahead of a single
// execution unit that handles one request at a time. An allocate scans the map
// one frame per cycle through the configured regions in order, then marks each frame
// of the first run that fits as used, reading and writing its map word; a free marks
// each frame that falls in a region free and skips one that does not. Requests of
// zero frames go straight to the result. The map memory has a single read port and
// a single write port.
module page_frame_bitmap_allocator_core import pfba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [FRAME_W-1:0] wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [CNT_W-1:0]   count,
	input  logic [ADDR_W-1:0]  phys_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ADDR_W-1:0]  alloc_address,
	output logic [1:0]         status
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE0: cfg_q.base[0]   <= wr_data;
				REG_LEN0:  cfg_q.frames[0] <= wr_data[CNT_W-1:0];
				REG_BASE1: cfg_q.base[1]   <= wr_data;
				REG_LEN1:  cfg_q.frames[1] <= wr_data[CNT_W-1:0];
				REG_BASE2: cfg_q.base[2]   <= wr_data;
				REG_LEN2:  cfg_q.frames[2] <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	pfba_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.count        (count),
		.phys_address (phys_address),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop)
	);

	pfba_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.alloc_address (alloc_address),
		.status        (status)
	);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NOFIT || status == ST_RANGE))
		else $error("status code out of range");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOFIT |-> alloc_address == '0)
		else $error("failed allocate returned an address");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> alloc_address == '0)
		else $error("free returned an address");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("pop from empty queue");

endmodule
